// ===== rtl/chg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the context hash generator.
package chg_pkg;

  localparam int unsigned HIST_TAPS  = 16;  // deepest byte any hash reaches
  localparam int unsigned MAX_ORDERS = 16;

  localparam logic [63:0] SEED_A    = 64'h08088405edb88320;
  localparam logic [63:0] SEED_B    = 64'haaaaaaaa55555555;
  localparam logic [31:0] MUL_A     = 32'h08088405;
  localparam logic [31:0] MUL_B     = 32'h7fffffed;

  // Mask table holds 1 << MASK_BITS slots, weight table 3 << WEIGHT_LOW_BITS slots
  localparam int unsigned MASK_BITS       = 26;
  localparam int unsigned WEIGHT_LOW_BITS = 28;
  localparam int unsigned RED_STEPS       = 2;  // nibble sum, then modulo 3

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_MIX,
    ST_FOLD,
    ST_REDUCE,
    ST_PUSH
  } ctrl_state_t;

  // One mix step, split around the shared 32x32 multiplier.
  typedef enum logic [2:0] {
    MIX_NONE,
    MIX_A_XOR,   // a ^= x, low partial product of a
    MIX_A_MUL,   // a = low product + high partial product << 32
    MIX_A_FOLD,  // a += a >> 32
    MIX_B_ADD,   // b += a
    MIX_B_LO,    // low partial product of b
    MIX_B_MUL,   // b = low product + high partial product << 32
    MIX_B_XOR    // b ^= b >> 32, b ^= b >> 48, b ^= x
  } mix_op_t;

  typedef struct packed {
    logic        push_byte;
    logic        seed_load;
    logic        x_load_byte;
    logic [3:0]  hist_idx;
    mix_op_t     mix_op;
    logic        red_load;
    logic        red_step;
    logic        out_load;
    logic [4:0]  order;
    logic        last;
    logic [1:0]  skip;
  } chg_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } chg_sts_t;

endpackage

// ===== rtl/chg_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the context hash generator: sequences orders, mix phases and reduction.
module chg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_data,
  output chg_pkg::chg_cmd_t cmd,
  input  chg_pkg::chg_sts_t sts
);

  chg_pkg::ctrl_state_t state_r, state_nxt;
  chg_pkg::mix_op_t     phase_r, phase_nxt;
  logic [4:0]           order_r, order_nxt;
  logic [4:0]           k_r, k_nxt;
  logic                 red_cnt_r, red_cnt_nxt;
  logic [1:0]           skip_r;
  logic [4:0]           orders;
  logic                 step_done;
  logic                 order_done;

  assign orders     = 5'(chg_pkg::MAX_ORDERS) - 5'({skip_r, 2'b00});
  assign step_done  = (phase_r == chg_pkg::MIX_B_XOR);
  assign order_done = step_done && (k_r == order_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= chg_pkg::ST_IDLE;
      phase_r   <= chg_pkg::MIX_NONE;
      order_r   <= '0;
      k_r       <= '0;
      red_cnt_r <= '0;
      skip_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      order_r   <= order_nxt;
      k_r       <= k_nxt;
      red_cnt_r <= red_cnt_nxt;
      if (cfg_valid) begin
        skip_r <= cfg_data;
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      chg_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = chg_pkg::ST_SEED;
      end
      chg_pkg::ST_SEED:   state_nxt = chg_pkg::ST_MIX;
      chg_pkg::ST_MIX: begin
        if (order_done) state_nxt = chg_pkg::ST_FOLD;
      end
      chg_pkg::ST_FOLD:   state_nxt = chg_pkg::ST_REDUCE;
      chg_pkg::ST_REDUCE: begin
        if (red_cnt_r == 1'(chg_pkg::RED_STEPS - 1)) state_nxt = chg_pkg::ST_PUSH;
      end
      chg_pkg::ST_PUSH: begin
        if (!sts.out_blocked) begin
          state_nxt = (order_r == orders) ? chg_pkg::ST_IDLE : chg_pkg::ST_SEED;
        end
      end
      default: state_nxt = chg_pkg::ST_IDLE;
    endcase
  end

  // Counters
  always_comb begin
    phase_nxt   = phase_r;
    order_nxt   = order_r;
    k_nxt       = k_r;
    red_cnt_nxt = red_cnt_r;
    case (state_r)
      chg_pkg::ST_IDLE: begin
        order_nxt = 5'd1;
      end
      chg_pkg::ST_SEED: begin
        k_nxt     = '0;
        phase_nxt = chg_pkg::MIX_A_XOR;
      end
      chg_pkg::ST_MIX: begin
        case (phase_r)
          chg_pkg::MIX_A_XOR:  phase_nxt = chg_pkg::MIX_A_MUL;
          chg_pkg::MIX_A_MUL:  phase_nxt = chg_pkg::MIX_A_FOLD;
          chg_pkg::MIX_A_FOLD: phase_nxt = chg_pkg::MIX_B_ADD;
          chg_pkg::MIX_B_ADD:  phase_nxt = chg_pkg::MIX_B_LO;
          chg_pkg::MIX_B_LO:   phase_nxt = chg_pkg::MIX_B_MUL;
          chg_pkg::MIX_B_MUL:  phase_nxt = chg_pkg::MIX_B_XOR;
          default:             phase_nxt = chg_pkg::MIX_A_XOR;
        endcase
        if (step_done) k_nxt = k_r + 5'd1;
      end
      chg_pkg::ST_FOLD: begin
        red_cnt_nxt = '0;
      end
      chg_pkg::ST_REDUCE: begin
        red_cnt_nxt = red_cnt_r + 1'b1;
      end
      chg_pkg::ST_PUSH: begin
        if (!sts.out_blocked) order_nxt = order_r + 5'd1;
      end
      default: begin
        phase_nxt = chg_pkg::MIX_NONE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_tready       = (state_r == chg_pkg::ST_IDLE);
    cfg_ready       = 1'b1;
    cmd.push_byte   = (state_r == chg_pkg::ST_IDLE) && in_tvalid;
    cmd.seed_load   = (state_r == chg_pkg::ST_SEED);
    cmd.x_load_byte = (state_r == chg_pkg::ST_MIX) && step_done && !order_done;
    cmd.hist_idx    = {2'b00, skip_r} + k_r[3:0];
    cmd.mix_op      = (state_r == chg_pkg::ST_MIX) ? phase_r : chg_pkg::MIX_NONE;
    cmd.red_load    = (state_r == chg_pkg::ST_FOLD);
    cmd.red_step    = (state_r == chg_pkg::ST_REDUCE);
    cmd.out_load    = (state_r == chg_pkg::ST_PUSH) && !sts.out_blocked;
    cmd.order       = order_r;
    cmd.last        = (order_r == orders);
    cmd.skip        = skip_r;
  end

endmodule

// ===== rtl/chg_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the context hash generator: history, mix unit, slot reduction, output register.
module chg_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  chg_pkg::chg_cmd_t cmd,
  output chg_pkg::chg_sts_t sts,
  input  logic [7:0]        in_byte,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [4:0]        out_order,
  output logic [63:0]       out_high,
  output logic [63:0]       out_low,
  output logic [25:0]       out_mask,
  output logic [29:0]       out_weight,
  output logic              out_last
);

  localparam int unsigned HI_NIBBLES = (64 - chg_pkg::WEIGHT_LOW_BITS) / 4;

  logic [7:0]  hist_r [chg_pkg::HIST_TAPS];
  logic [63:0] a_r, b_r, prod_lo_r;
  logic [16:0] x_r;
  logic [63:0] fold_r;
  logic [7:0]  nib_r, nib_nxt;
  logic [1:0]  m3_r, m3_nxt;
  logic        out_valid_r;
  logic [4:0]  out_order_r;
  logic [63:0] out_high_r, out_low_r;
  logic [25:0] out_mask_r;
  logic [29:0] out_weight_r;
  logic        out_last_r;

  logic [31:0] mul_src, mul_k;
  logic [63:0] product;
  logic [63:0] b_x1, b_x2;
  logic [4:0]  dig1;
  logic [3:0]  dig2, r12, r6, r3;

  // Shared multiplier, operands picked by mix phase
  always_comb begin
    case (cmd.mix_op)
      chg_pkg::MIX_A_XOR: begin
        mul_src = a_r[31:0] ^ {15'b0, x_r};
        mul_k   = chg_pkg::MUL_A;
      end
      chg_pkg::MIX_A_MUL: begin
        mul_src = a_r[63:32];
        mul_k   = chg_pkg::MUL_A;
      end
      chg_pkg::MIX_B_LO: begin
        mul_src = b_r[31:0];
        mul_k   = chg_pkg::MUL_B;
      end
      chg_pkg::MIX_B_MUL: begin
        mul_src = b_r[63:32];
        mul_k   = chg_pkg::MUL_B;
      end
      default: begin
        mul_src = '0;
        mul_k   = '0;
      end
    endcase
    product = {32'b0, mul_src} * {32'b0, mul_k};
    b_x1    = b_r ^ (b_r >> 32);
    b_x2    = b_x1 ^ (b_x1 >> 48);
  end

  // Weight slot: low bits pass through, the upper bits reduce modulo 3.
  // 16 is 1 modulo 3, so a sum of nibbles keeps the residue.
  always_comb begin
    nib_nxt = '0;
    for (int i = 0; i < HI_NIBBLES; i++) begin
      nib_nxt = nib_nxt + 8'(fold_r[chg_pkg::WEIGHT_LOW_BITS + 4*i +: 4]);
    end
    dig1   = 5'(nib_r[7:4]) + 5'(nib_r[3:0]);
    dig2   = {3'b000, dig1[4]} + dig1[3:0];
    r12    = (dig2 >= 4'd12) ? dig2 - 4'd12 : dig2;
    r6     = (r12 >= 4'd6) ? r12 - 4'd6 : r12;
    r3     = (r6 >= 4'd3) ? r6 - 4'd3 : r6;
    m3_nxt = r3[1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < chg_pkg::HIST_TAPS; i++) begin
        hist_r[i] <= '0;
      end
    end else if (cmd.push_byte) begin
      for (int i = chg_pkg::HIST_TAPS - 1; i > 0; i--) begin
        hist_r[i] <= hist_r[i-1];
      end
      hist_r[0] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seed_load) begin
      a_r <= chg_pkg::SEED_A;
      b_r <= chg_pkg::SEED_B;
      x_r <= 17'({cmd.order, 6'b0, cmd.skip});
    end else begin
      case (cmd.mix_op)
        chg_pkg::MIX_A_XOR: begin
          a_r       <= a_r ^ {47'b0, x_r};
          prod_lo_r <= product;
        end
        chg_pkg::MIX_A_MUL:  a_r <= prod_lo_r + {product[31:0], 32'b0};
        chg_pkg::MIX_A_FOLD: a_r <= a_r + (a_r >> 32);
        chg_pkg::MIX_B_ADD:  b_r <= b_r + a_r;
        chg_pkg::MIX_B_LO:   prod_lo_r <= product;
        chg_pkg::MIX_B_MUL:  b_r <= prod_lo_r + {product[31:0], 32'b0};
        chg_pkg::MIX_B_XOR:  b_r <= b_x2 ^ {47'b0, x_r};
        default: ;
      endcase
      if (cmd.x_load_byte) begin
        x_r <= {1'b1, 8'b0, hist_r[cmd.hist_idx]};
      end
    end
  end

  // Fold, then nibble sum and modulo 3 over two steps
  always_ff @(posedge clk) begin
    if (cmd.red_load) begin
      fold_r <= a_r ^ b_r;
    end else if (cmd.red_step) begin
      nib_r <= nib_nxt;
      m3_r  <= m3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_order_r  <= cmd.order;
      out_high_r   <= a_r;
      out_low_r    <= b_r;
      out_mask_r   <= fold_r[chg_pkg::MASK_BITS-1:0];
      out_weight_r <= {m3_r, fold_r[chg_pkg::WEIGHT_LOW_BITS-1:0]};
      out_last_r   <= cmd.last;
    end
  end

  assign sts.out_blocked = out_valid_r && !out_ready;
  assign out_valid  = out_valid_r;
  assign out_order  = out_order_r;
  assign out_high   = out_high_r;
  assign out_low    = out_low_r;
  assign out_mask   = out_mask_r;
  assign out_weight = out_weight_r;
  assign out_last   = out_last_r;

endmodule

// ===== rtl/context_hash_generator_unit.sv =====
`timescale 1ns / 1ps
// Top level of the context hash generator: controller, datapath and port packing.
//
//   channel  direction  beat                               marker
//   in_      slave      in_tdata[7:0] = new_byte           -
//   out_     master     order, hash words, slots           out_tlast = last_of_run
//   cfg_     slave      cfg_data[1:0] = context_skip       -
//
// Each input beat pushes one byte into a 16-byte history and yields
// N = 16 - 4*context_skip result beats, orders 1..N in rising order.
// Per order n: a seed step, n+1 mix steps on one shared 32x32 multiplier
// (seven phases per mix step), a fold, a nibble sum and a modulo-3 step
// for the slots (mask slot is the low 26 folded bits; weight slot keeps
// the low 28 bits and takes the upper 36 bits modulo 3) and a push.
// Reset (synchronous, active low) clears the history to zero bytes, the
// skip register to 0 and all control; hash registers are not reset.
// One output register parts the sides: the next byte is accepted while the
// last result still waits, and a stalled result holds the sequencer in its
// push cycle only. Write cfg only while idle.
module context_hash_generator_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,    // [7:0] new_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata,   // [4:0] context_order, [68:5] hash_high,
                                    // [132:69] hash_low, [158:133] mask_slot,
                                    // [188:159] weight_slot, [191:189] zero
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_data
);

  chg_pkg::chg_cmd_t cmd;
  chg_pkg::chg_sts_t sts;

  logic [4:0]  res_order;
  logic [63:0] res_high, res_low;
  logic [25:0] res_mask;
  logic [29:0] res_weight;

  // Sequence seed, mix steps, reduction and push for every order
  chg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Hold history and hash state, reduce and register each result
  chg_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_byte    (in_tdata),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_order  (res_order),
    .out_high   (res_high),
    .out_low    (res_low),
    .out_mask   (res_mask),
    .out_weight (res_weight),
    .out_last   (out_tlast)
  );

  // Pack result fields, lowest first
  assign out_tdata = {3'b000, res_weight, res_mask, res_low, res_high, res_order};

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the context hash generator unit: table-driven opening, random bytes.
module tb;

  localparam int unsigned HIST_DEPTH      = 32;
  localparam int unsigned MAX_ORDER_COUNT = 16;
  localparam logic [63:0] HASH_SEED_A     = 64'h08088405edb88320;
  localparam logic [63:0] HASH_SEED_B     = 64'haaaaaaaa55555555;
  localparam logic [63:0] MIX_MUL_A       = 64'h0000000008088405;
  localparam logic [63:0] MIX_MUL_B       = 64'h000000007fffffed;
  localparam logic [63:0] BYTE_BIAS       = 64'd65536;
  localparam logic [63:0] ORDER_SCALE     = 64'd256;
  localparam logic [63:0] MASK_SLOT_COUNT = 64'd67108864;
  localparam logic [63:0] WGHT_SLOT_COUNT = 64'd805306368;

  localparam int unsigned RESET_CYCLES  = 7;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 40;
  localparam int unsigned HOLD_CYCLES   = 2500;
  localparam int unsigned SEG_BYTES     = 20;
  localparam int unsigned CYCLE_LIMIT   = 4000000;
  localparam int unsigned PRINT_CAP     = 200;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
  } hash_state_t;

  typedef struct {
    logic [4:0]  order;
    logic [63:0] hash_hi;
    logic [63:0] hash_lo;
    logic [25:0] mask_slot;
    logic [29:0] weight_slot;
    logic        last;
  } hash_result_t;

  typedef enum logic {
    ROW_BYTE,
    ROW_SKIP
  } row_kind_t;

  // orders: burst length given in the row; 0 = derive it from the active skip setting
  typedef struct {
    row_kind_t   kind;
    logic [7:0]  value;
    int unsigned orders;
  } stim_row_t;

  localparam int unsigned DIR_ROWS = 22;

  stim_row_t opening_rows [DIR_ROWS] = '{
    '{ROW_BYTE, 8'h00, 16},  // right after reset: history still all zero bytes
    '{ROW_BYTE, 8'hff, 16},
    '{ROW_BYTE, 8'h01, 0},
    '{ROW_BYTE, 8'h80, 0},
    '{ROW_SKIP, 8'h03, 0},   // largest skip, shortest burst
    '{ROW_BYTE, 8'h00, 4},
    '{ROW_BYTE, 8'hff, 4},
    '{ROW_BYTE, 8'h55, 0},
    '{ROW_BYTE, 8'haa, 0},
    '{ROW_SKIP, 8'h01, 0},
    '{ROW_BYTE, 8'h7f, 12},
    '{ROW_BYTE, 8'hfe, 0},
    '{ROW_SKIP, 8'h02, 0},
    '{ROW_BYTE, 8'h0f, 8},
    '{ROW_BYTE, 8'hf0, 0},
    '{ROW_SKIP, 8'h00, 0},   // back to the full sixteen orders
    '{ROW_BYTE, 8'hff, 16},
    '{ROW_BYTE, 8'hff, 0},
    '{ROW_BYTE, 8'h00, 0},
    '{ROW_SKIP, 8'h03, 0},
    '{ROW_BYTE, 8'h00, 4},
    '{ROW_SKIP, 8'h00, 0}
  };

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata   = 8'h00;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [191:0] out_tdata;
  logic         out_tlast;
  logic         cfg_valid  = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_data   = 2'd0;

  // predictor state
  logic [7:0]   recent_bytes [HIST_DEPTH];
  logic [1:0]   active_skip = 2'd0;
  hash_result_t hash_results_due [$];

  int unsigned  src_idle_pct   = 0;
  int unsigned  sink_idle_pct  = 0;
  bit           hold_off_req   = 1'b0;
  int unsigned  mismatch_count = 0;
  int unsigned  results_seen   = 0;
  int unsigned  bytes_sent     = 0;
  int unsigned  skip_writes    = 0;
  int unsigned  hold_offs      = 0;
  int unsigned  cycle_count    = 0;

  context_hash_generator_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d results still due", $time, hash_results_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < HIST_DEPTH; i++) recent_bytes[i] = 8'h00;
  end

  function automatic hash_state_t mix_round(hash_state_t s, logic [63:0] x);
    hash_state_t r;
    r   = s;
    r.a = r.a ^ x;
    r.a = r.a * MIX_MUL_A;
    r.a = r.a + (r.a >> 32);
    r.b = r.b + r.a;
    r.b = r.b * MIX_MUL_B;
    r.b = r.b ^ (r.b >> 32);
    r.b = r.b ^ (r.b >> 48);
    r.b = r.b ^ x;
    return r;
  endfunction

  // Push the byte, then queue one hash per order, lowest order first.
  task automatic predict_hash_run(input logic [7:0] b, input int unsigned n_orders);
    hash_state_t  s;
    hash_result_t r;
    logic [63:0]  folded;
    logic [7:0]   tap;
    int unsigned  idx;
    for (int i = HIST_DEPTH - 1; i > 0; i--) recent_bytes[i] = recent_bytes[i-1];
    recent_bytes[0] = b;
    for (int unsigned ord = 1; ord <= n_orders; ord++) begin
      s.a = HASH_SEED_A;
      s.b = HASH_SEED_B;
      s   = mix_round(s, 64'(ord) * ORDER_SCALE + 64'(active_skip));
      for (int unsigned i = 0; i < ord; i++) begin
        idx = int'(active_skip) + i;
        tap = (idx < HIST_DEPTH) ? recent_bytes[idx] : 8'h00;
        s   = mix_round(s, BYTE_BIAS + 64'(tap));
      end
      folded        = s.a ^ s.b;
      r.order       = 5'(ord);
      r.hash_hi     = s.a;
      r.hash_lo     = s.b;
      r.mask_slot   = 26'(folded % MASK_SLOT_COUNT);
      r.weight_slot = 30'(folded % WGHT_SLOT_COUNT);
      r.last        = (ord == n_orders);
      hash_results_due.push_back(r);
    end
  endtask

  // Called right after a falling edge; returns right after one.
  task automatic send_byte(input logic [7:0] b, input int unsigned n_orders);
    int unsigned burst;
    burst = (n_orders != 0) ? n_orders : MAX_ORDER_COUNT - 4 * int'(active_skip);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_hash_run(b, burst);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    in_tvalid = 1'b0;
    while (hash_results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_skip(input logic [1:0] v);
    wait_for_drain();
    cfg_valid = 1'b1;
    cfg_data  = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    active_skip = v;
    skip_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
    end
  endtask

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_off_req = 1'b0;
        hold_offs++;
      end else begin
        out_tready = ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    hash_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (hash_results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
          $display("%0t ns: unexpected result, expected none, actual 0x%0h", $time, out_tdata);
      end else begin
        want = hash_results_due.pop_front();
        check_field("context_order", 64'(want.order),       64'(out_tdata[4:0]));
        check_field("hash_high",     want.hash_hi,          out_tdata[68:5]);
        check_field("hash_low",      want.hash_lo,          out_tdata[132:69]);
        check_field("mask_slot",     64'(want.mask_slot),   64'(out_tdata[158:133]));
        check_field("weight_slot",   64'(want.weight_slot), 64'(out_tdata[188:159]));
        check_field("pad",           64'd0,                 64'(out_tdata[191:189]));
        check_field("last_of_run",   64'(want.last),        64'(out_tlast));
        results_seen++;
      end
    end
  end

  initial begin
    logic [1:0]  seg_skip;
    logic [7:0]  b;
    int unsigned skip_off;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    src_idle_pct  = 22;
    sink_idle_pct = 80;
    for (int unsigned row = 0; row < DIR_ROWS; row++) begin
      if (opening_rows[row].kind == ROW_SKIP)
        write_skip(opening_rows[row].value[1:0]);
      else
        send_byte(opening_rows[row].value, opening_rows[row].orders);
    end

    for (int unsigned phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 22;
          sink_idle_pct = 80;
        end
        1: begin
          src_idle_pct  = 80;
          sink_idle_pct = 22;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      skip_off = $urandom_range(3);
      for (int unsigned seg = 0; seg < 4; seg++) begin
        seg_skip = 2'(seg + skip_off);
        write_skip(seg_skip);
        // stall the result side long enough to back the block up into its input
        if (phase == 2 && seg == 0) hold_off_req = 1'b1;
        for (int unsigned k = 0; k < SEG_BYTES; k++) begin
          case ($urandom_range(7))
            0:       b = 8'h00;
            1:       b = 8'hff;
            default: b = 8'($urandom_range(255));
          endcase
          send_byte(b, 0);
          // pause the source mid-segment until every hash has come out
          if (phase == 1 && seg == 1 && k == SEG_BYTES / 2) wait_for_drain();
        end
      end
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d bytes and %0d hash results over %0d skip writes (codes 0..3),",
             bytes_sent, results_seen, skip_writes);
    $display("three idling mixes and %0d long result hold-off(s); %0d mismatches.",
             hold_offs, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/chg_pkg.sv
rtl/chg_ctrl.sv
rtl/chg_datapath.sv
rtl/context_hash_generator_unit.sv
tb/tb.sv
